@@ hdl/kea_pkg.sv @@
// shared types, constants and functions for the color key edge antialias block
// no dependencies; used by the top level key_edge_antialias_3x3
package kea_pkg;

  localparam int PIX_W         = 32;
  localparam int SZ_W          = 11;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int CFG_IDX_W     = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AA_ENABLE   = 2'd0,
    REG_KEY_COLOR   = 2'd1,
    REG_IMAGE_WIDTH = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  // 3x3 window, index = row * 3 + col, row 0 is the upper line
  typedef logic [8:0][PIX_W-1:0] win_t;

  // position info carried with one pixel through the pipeline
  typedef struct packed {
    logic emit0;     // this transfer produces a regular result
    logic last;      // final transfer of the frame, produces the closing pixel too
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic top2_ok;   // closing pixel: upper neighbors inside the frame
    logic left2_ok;  // closing pixel: left neighbors inside the frame
  } pos_t;

  // one queued result
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_in_run;
    logic             frame_end;
  } out_ent_t;

  // shift the window left by one column and load the new right column
  function automatic win_t shift_win(win_t w, logic [PIX_W-1:0] up,
                                     logic [PIX_W-1:0] mid, logic [PIX_W-1:0] bot);
    win_t n;
    n    = w;
    n[0] = w[1];
    n[1] = w[2];
    n[2] = up;
    n[3] = w[4];
    n[4] = w[5];
    n[5] = mid;
    n[6] = w[7];
    n[7] = w[8];
    n[8] = bot;
    return n;
  endfunction

  // replace a key pixel by the sum of its valid neighbors, each channel over 8
  function automatic logic [PIX_W-1:0] blend_px(win_t w, logic [PIX_W-1:0] key,
                                                logic en, logic t_ok, logic b_ok,
                                                logic l_ok, logic r_ok);
    logic [7:0]       sa;
    logic [7:0]       sr;
    logic [7:0]       sg;
    logic [7:0]       sb;
    logic             corner;
    logic             side;
    logic             vert;
    logic             inpos;
    logic [PIX_W-1:0] v;
    sa     = '0;
    sr     = '0;
    sg     = '0;
    sb     = '0;
    corner = 1'b0;
    side   = 1'b0;
    vert   = 1'b0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        v     = w[dr * 3 + dc];
        inpos = !(dr == 1 && dc == 1) && !(dr == 0 && !t_ok) && !(dr == 2 && !b_ok) &&
                !(dc == 0 && !l_ok) && !(dc == 2 && !r_ok);
        if (inpos && v != '0 && v != key) begin
          sa = sa + {3'b000, v[31:27]};
          sr = sr + {3'b000, v[23:19]};
          sg = sg + {3'b000, v[15:11]};
          sb = sb + {3'b000, v[7:3]};
          if (dr != 1 && dc != 1) begin
            corner = 1'b1;
          end else if (dc != 1) begin
            side = 1'b1;
          end else begin
            vert = 1'b1;
          end
        end
      end
    end
    if (!en || w[4] != key || !(corner && side && vert)) begin
      return w[4];
    end
    return {sa, sr, sg, sb};
  endfunction

endpackage

@@ hdl/kea_ram.sv @@
// generic single-write, single-read RAM with registered read data
// no dependencies; instanced for the line buffers of the antialias block
module kea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, read port returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/key_edge_antialias_3x3.sv @@
// Color key edge antialias over a 3x3 window on a raster ARGB pixel stream.
// The block takes one pixel per clock while in_stall is low, with no bubbles between
// rows or frames; each pixel goes through a line buffer read, a window update and a
// blend stage, and each result leaves from an 8-entry output queue. The rate is set
// by the two line buffer RAMs (one read and one write per pixel each). Results come
// out one row and one pixel behind the input, so the first image_width+1 pixels of
// a frame give nothing and the host sends one extra row to flush; the last flush
// pixel gives two results, the second marked with frame_end. The line buffers are
// not cleared after reset. The host must write configuration only while the block
// is idle; the block does not enforce it. Depends on kea_pkg and kea_ram.
module key_edge_antialias_3x3 #(
  parameter int MAX_WIDTH = kea_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kea_pkg::PIX_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kea_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kea_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_last_in_run,
  output logic                          out_frame_end
);
  import kea_pkg::*;

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int FD   = 8;
  localparam int FAW  = $clog2(FD);
  localparam int FCW  = FAW + 1;
  localparam int OCW  = FCW + 1;

  function automatic logic [SZ_W-1:0] eff_size(logic [SZ_W-1:0] v, int maxv);
    if (v == '0) begin
      return SZ_W'(1);
    end
    if (int'(v) > maxv) begin
      return SZ_W'(maxv);
    end
    return v;
  endfunction

  // configuration registers
  logic             aa_enable_r;
  logic [PIX_W-1:0] key_color_r;
  logic [SZ_W-1:0]  image_width_r;
  logic [SZ_W-1:0]  image_height_r;
  logic             size_wr;

  // frame position
  logic [SZ_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [SZ_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [SZ_W-1:0] wd, ht, c, r;
  logic            c_end;
  pos_t            pos0;
  logic            in_acc;
  logic [AW-1:0]   rd_addr;

  // pipeline
  logic             s1_vld_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [AW-1:0]    s1_addr_r;
  pos_t             s1_pos_r;
  logic             s2_vld_r;
  pos_t             s2_pos_r;
  logic             fwd_vld_r;
  logic [PIX_W-1:0] fwd_up_r;
  logic [PIX_W-1:0] fwd_mid_r;
  logic [PIX_W-1:0] upper_rd, middle_rd;
  logic [PIX_W-1:0] up_eff, mid_eff;
  win_t             win_r;
  win_t             win_flush;
  logic [PIX_W-1:0] res0, res1;

  // output queue
  out_ent_t       fifo_mem [FD];
  logic [FAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0] cnt_r, cnt_nxt;
  logic           push0, push1, pop;
  out_ent_t       e0, e1;
  logic [OCW-1:0] occ;

  // register writes
  assign size_wr = cfg_we && (cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH ||
                              cfg_reg_t'(cfg_index) == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aa_enable_r    <= 1'b0;
      key_color_r    <= '0;
      image_width_r  <= SZ_W'(128);
      image_height_r <= SZ_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AA_ENABLE:    aa_enable_r    <= cfg_wdata[0];
        REG_KEY_COLOR:    key_color_r    <= cfg_wdata;
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[SZ_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[SZ_W-1:0];
      endcase
    end
  end

  // clamped position of the incoming pixel and its neighbor masks
  always_comb begin
    wd    = eff_size(image_width_r, MAX_WIDTH);
    ht    = eff_size(image_height_r, MAX_HEIGHT);
    c     = (col_cnt_r >= wd) ? wd - SZ_W'(1) : col_cnt_r;
    r     = (row_cnt_r > ht) ? ht : row_cnt_r;
    c_end = (c == wd - SZ_W'(1));
    pos0.last     = (r == ht) && c_end;
    pos0.emit0    = (r >= SZ_W'(2)) || (r == SZ_W'(1) && c != '0);
    pos0.top_ok   = (c != '0) ? (r != SZ_W'(1)) : (r != SZ_W'(2));
    pos0.bot_ok   = (c != '0) ? (r < ht) : 1'b1;
    pos0.left_ok  = (c != '0) ? (c != SZ_W'(1)) : (wd != SZ_W'(1));
    pos0.right_ok = (c != '0);
    pos0.top2_ok  = (ht != SZ_W'(1));
    pos0.left2_ok = (wd != SZ_W'(1));
    rd_addr       = AW'(c);
  end

  assign in_acc = in_valid && !in_stall;

  // next frame position
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    priority if (size_wr) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (in_acc && pos0.last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (in_acc && c_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = r + SZ_W'(1);
    end else if (in_acc) begin
      col_cnt_nxt = c + SZ_W'(1);
      row_cnt_nxt = r;
    end else begin
      col_cnt_nxt = col_cnt_r;
      row_cnt_nxt = row_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // line buffers: upper takes the old middle entry, middle takes the new pixel
  kea_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_addr_r),
    .wdata (mid_eff),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (upper_rd)
  );

  kea_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_addr_r),
    .wdata (s1_px_r),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (middle_rd)
  );

  // forward the write that collided with this read (single-column frames)
  assign up_eff  = fwd_vld_r ? fwd_up_r : upper_rd;
  assign mid_eff = fwd_vld_r ? fwd_mid_r : middle_rd;

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_acc;
      s2_vld_r  <= s1_vld_r;
      fwd_vld_r <= in_acc && s1_vld_r && (s1_addr_r == rd_addr);
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_pixel_in;
      s1_addr_r <= rd_addr;
      s1_pos_r  <= pos0;
    end
    fwd_up_r  <= mid_eff;
    fwd_mid_r <= s1_px_r;
    s2_pos_r  <= s1_pos_r;
  end

  // window update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_vld_r) begin
      win_r <= shift_win(win_r, up_eff, mid_eff, s1_px_r);
    end
  end

  // blend: regular result and the frame closing pixel
  assign win_flush = shift_win(win_r, '0, '0, '0);
  assign res0 = blend_px(win_r, key_color_r, aa_enable_r, s2_pos_r.top_ok,
                         s2_pos_r.bot_ok, s2_pos_r.left_ok, s2_pos_r.right_ok);
  assign res1 = blend_px(win_flush, key_color_r, aa_enable_r, s2_pos_r.top2_ok,
                         1'b0, s2_pos_r.left2_ok, 1'b0);

  // queue entries for this pixel
  always_comb begin
    push0 = s2_vld_r && (s2_pos_r.emit0 || s2_pos_r.last);
    push1 = s2_vld_r && s2_pos_r.emit0 && s2_pos_r.last;
    e1.pixel       = res1;
    e1.last_in_run = 1'b1;
    e1.frame_end   = 1'b1;
    if (s2_pos_r.emit0) begin
      e0.pixel       = res0;
      e0.last_in_run = !s2_pos_r.last;
      e0.frame_end   = 1'b0;
    end else begin
      e0 = e1;
    end
  end

  assign pop     = out_valid && !out_stall;
  assign cnt_nxt = cnt_r + FCW'(push0) + FCW'(push1) - FCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FAW'(push0) + FAW'(push1);
      rd_ptr_r <= rd_ptr_r + FAW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_mem[wr_ptr_r] <= e0;
    end
    if (push1) begin
      fifo_mem[wr_ptr_r + FAW'(1)] <= e1;
    end
  end

  // output side
  assign out_valid       = (cnt_r != '0);
  assign out_pixel_out   = fifo_mem[rd_ptr_r].pixel;
  assign out_last_in_run = fifo_mem[rd_ptr_r].last_in_run;
  assign out_frame_end   = fifo_mem[rd_ptr_r].frame_end;

  // hold input while queue space for the pixels in flight plus one more is lacking
  assign occ      = OCW'(cnt_r) + (s1_vld_r ? OCW'(2) : '0) + (s2_vld_r ? OCW'(2) : '0);
  assign in_stall = (occ > OCW'(FD - 2));

endmodule

@@ hdl/kea_chk.sv @@
// port-level checks for the color key edge antialias block
// bound to key_edge_antialias_3x3; needs no package
module kea_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pixel_out,
  input logic        out_last_in_run,
  input logic        out_frame_end
);

  // the frame closing pixel is always the last result of its input transfer
  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last_in_run)
    else $error("frame_end without last_in_run");

  // a stalled result stays offered with the same contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) &&
                               $stable(out_last_in_run) && $stable(out_frame_end))
    else $error("stalled result changed");

  // once the pipeline has drained and nothing waits, the input is open
  a_drained_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid ##1 !in_valid ##1 !out_valid |-> !in_stall)
    else $error("input stalled with empty pipeline");

endmodule

bind key_edge_antialias_3x3 kea_chk u_kea_chk (.*);
